[hw/rtl/ignition_voltage_detector_macros.svh]
// Assertion macros for the ignition voltage detector RTL.
// Included by modules that carry concurrent checks; expects clk and rst_n in scope.
`ifndef IGNITION_VOLTAGE_DETECTOR_MACROS_SVH
`define IGNITION_VOLTAGE_DETECTOR_MACROS_SVH

`ifndef ASSERT_OFF

// Checked only outside reset.
`define IVD_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checked on every edge, reset included.
`define IVD_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);

`else

`define IVD_ASSERT(label, prop, msg)
`define IVD_ASSERT_ALWAYS(label, prop, msg)

`endif

`endif

[hw/rtl/ivd_pkg.sv]
// Shared widths, register indexes, reset values and engine modes
// for the ignition voltage detector. No dependencies.
`timescale 1ns / 1ps

package ivd_pkg;

    localparam int SAMPLE_WIDTH = 13;
    localparam int COUNT_WIDTH  = 8;
    localparam int SUM_WIDTH    = SAMPLE_WIDTH + COUNT_WIDTH;
    localparam int AVG_WIDTH    = 13;
    localparam int RUN_WIDTH    = 32;
    localparam int WINDOW_WIDTH = 8;
    localparam int THRESH_WIDTH = 13;
    localparam int MODE_WIDTH   = 2;
    localparam int BITCNT_WIDTH = $clog2(SUM_WIDTH + 1);

    localparam int IN_FIELDS_WIDTH  = SAMPLE_WIDTH + 1;
    localparam int IN_DATA_WIDTH    = ((IN_FIELDS_WIDTH + 7) / 8) * 8;
    localparam int OUT_FIELDS_WIDTH = 1 + AVG_WIDTH + MODE_WIDTH + 1 + 1 + RUN_WIDTH + 1;
    localparam int OUT_DATA_WIDTH   = ((OUT_FIELDS_WIDTH + 7) / 8) * 8;

    localparam int CFG_INDEX_WIDTH = 2;
    localparam int CFG_DATA_WIDTH  = 13;

    localparam logic [CFG_INDEX_WIDTH-1:0] REG_WINDOW_SAMPLES = 2'd0;
    localparam logic [CFG_INDEX_WIDTH-1:0] REG_ON_THRESHOLD   = 2'd1;
    localparam logic [CFG_INDEX_WIDTH-1:0] REG_OFF_THRESHOLD  = 2'd2;

    localparam logic [WINDOW_WIDTH-1:0] WINDOW_RESET   = 8'd10;
    localparam logic [THRESH_WIDTH-1:0] ON_THR_RESET   = 13'd4200;
    localparam logic [THRESH_WIDTH-1:0] OFF_THR_RESET  = 13'd3800;
    localparam logic [AVG_WIDTH-1:0]    AVG_MAX        = {AVG_WIDTH{1'b1}};
    localparam logic [COUNT_WIDTH-1:0]  COUNT_MAX      = {COUNT_WIDTH{1'b1}};

    typedef enum logic [MODE_WIDTH-1:0] {
        MODE_IDLE = 2'd0,
        MODE_ON   = 2'd1,
        MODE_OFF  = 2'd2
    } engine_mode_t;

endpackage

[hw/rtl/ignition_voltage_detector.sv]
// Ignition voltage detector: windowed average of millivolt samples with an
// engine on/off decision. Depends on ivd_pkg and ignition_voltage_detector_macros.svh.
`timescale 1ns / 1ps

// A sample that does not close a window goes from acceptance through ST_EMIT to
// the output register (accept, then load the result). A sample that closes a
// window has its window sum divided by the sample count in a restoring divider
// that retires one quotient bit per cycle, then the engine decision is made in
// ST_DECIDE before the load. s_tready is low from acceptance until the result
// is loaded; the next sample is taken while a result waits on the master side,
// but a result that is still not taken holds back the one after. Config writes
// are always ready and are meant to happen while the block is idle.
`include "ignition_voltage_detector_macros.svh"

module ignition_voltage_detector
(
    input  logic                                    clk,
    input  logic                                    rst_n,
    // config write channel
    input  logic                                    cfg_valid,
    output logic                                    cfg_ready,
    input  logic [ivd_pkg::CFG_INDEX_WIDTH-1:0]     cfg_index,
    input  logic [ivd_pkg::CFG_DATA_WIDTH-1:0]      cfg_data,
    // sample stream
    input  logic                                    s_tvalid,
    output logic                                    s_tready,
    // [12:0] sample_mv, [13] ignition_active, [15:14] zero
    input  logic [ivd_pkg::IN_DATA_WIDTH-1:0]       s_tdata,
    // result stream
    output logic                                    m_tvalid,
    input  logic                                    m_tready,
    // [0] window_done, [13:1] average_mv, [15:14] engine_state, [16] engine_started,
    // [17] engine_stopped, [49:18] run_ticks, [50] stop_sampling, [55:51] zero
    output logic [ivd_pkg::OUT_DATA_WIDTH-1:0]      m_tdata
);

    localparam int SW = ivd_pkg::SAMPLE_WIDTH;
    localparam int CW = ivd_pkg::COUNT_WIDTH;
    localparam int UW = ivd_pkg::SUM_WIDTH;
    localparam int AW = ivd_pkg::AVG_WIDTH;
    localparam int RW = ivd_pkg::RUN_WIDTH;
    localparam int BW = ivd_pkg::BITCNT_WIDTH;
    localparam int PAD_WIDTH = ivd_pkg::OUT_DATA_WIDTH - ivd_pkg::OUT_FIELDS_WIDTH;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DIV,
        ST_DECIDE,
        ST_EMIT
    } state_t;

    // config registers
    logic [ivd_pkg::WINDOW_WIDTH-1:0] window_reg;
    logic [ivd_pkg::THRESH_WIDTH-1:0] on_thr_reg;
    logic [ivd_pkg::THRESH_WIDTH-1:0] off_thr_reg;

    // block state
    state_t                state_reg;
    logic [UW-1:0]         sum_reg;
    logic [CW-1:0]         count_reg;
    ivd_pkg::engine_mode_t mode_reg;
    logic [RW-1:0]         run_time_reg;
    logic [AW-1:0]         last_avg_reg;
    logic                  ign_reg;

    // divider
    logic [UW-1:0]         quo_reg;
    logic [CW-1:0]         rem_reg;
    logic [BW-1:0]         bit_cnt_reg;

    // flags of the result being built
    logic                  pend_done_reg;
    logic                  pend_started_reg;
    logic                  pend_stopped_reg;
    logic                  pend_stop_reg;

    // output register
    logic                  out_valid_reg;
    logic                  out_done_reg;
    logic [AW-1:0]         out_avg_reg;
    logic [1:0]            out_mode_reg;
    logic                  out_started_reg;
    logic                  out_stopped_reg;
    logic [RW-1:0]         out_run_reg;
    logic                  out_stop_reg;

    logic [SW-1:0]         in_sample;
    logic                  in_ign;
    logic                  in_accept;
    logic [UW-1:0]         sum_next;
    logic [CW-1:0]         count_next;
    logic [CW-1:0]         eff_window;
    logic                  window_close;

    logic [CW:0]           rem_shift;
    logic [CW+1:0]         rem_diff;
    logic                  rem_ge;

    logic [AW-1:0]         avg_sat;
    logic                  out_free;

    assign in_sample = s_tdata[SW-1:0];
    assign in_ign    = s_tdata[SW];
    assign s_tready  = (state_reg == ST_IDLE);
    assign in_accept = s_tvalid && s_tready;
    assign cfg_ready = 1'b1;

    assign sum_next   = sum_reg + UW'(in_sample);
    assign count_next = count_reg + CW'(1);

    // zero behaves as one; window capped at the largest count
    always_comb
    begin
        if (window_reg == '0)
            eff_window = CW'(1);
        else if (32'(window_reg) > 32'(ivd_pkg::COUNT_MAX))
            eff_window = ivd_pkg::COUNT_MAX;
        else
            eff_window = CW'(window_reg);
    end

    assign window_close = (count_next != '0) && (count_next >= eff_window);

    // one restoring step: shift in the next dividend bit, try the subtract
    assign rem_shift = {rem_reg, quo_reg[UW-1]};
    assign rem_diff  = {1'b0, rem_shift} - {2'b00, count_reg};
    assign rem_ge    = !rem_diff[CW+1];

    assign avg_sat = (quo_reg[UW-1:AW] != '0) ? ivd_pkg::AVG_MAX : quo_reg[AW-1:0];

    assign out_free = !out_valid_reg || m_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            window_reg       <= ivd_pkg::WINDOW_RESET;
            on_thr_reg       <= ivd_pkg::ON_THR_RESET;
            off_thr_reg      <= ivd_pkg::OFF_THR_RESET;
            state_reg        <= ST_IDLE;
            sum_reg          <= '0;
            count_reg        <= '0;
            mode_reg         <= ivd_pkg::MODE_IDLE;
            run_time_reg     <= '0;
            last_avg_reg     <= '0;
            ign_reg          <= 1'b0;
            quo_reg          <= '0;
            rem_reg          <= '0;
            bit_cnt_reg      <= '0;
            pend_done_reg    <= 1'b0;
            pend_started_reg <= 1'b0;
            pend_stopped_reg <= 1'b0;
            pend_stop_reg    <= 1'b0;
            out_valid_reg    <= 1'b0;
            out_done_reg     <= 1'b0;
            out_avg_reg      <= '0;
            out_mode_reg     <= '0;
            out_started_reg  <= 1'b0;
            out_stopped_reg  <= 1'b0;
            out_run_reg      <= '0;
            out_stop_reg     <= 1'b0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                unique case (cfg_index)
                    ivd_pkg::REG_WINDOW_SAMPLES:
                        window_reg <= cfg_data[ivd_pkg::WINDOW_WIDTH-1:0];
                    ivd_pkg::REG_ON_THRESHOLD:
                        on_thr_reg <= cfg_data[ivd_pkg::THRESH_WIDTH-1:0];
                    ivd_pkg::REG_OFF_THRESHOLD:
                        off_thr_reg <= cfg_data[ivd_pkg::THRESH_WIDTH-1:0];
                    default:
                        ;
                endcase
            end

            // in ST_EMIT the load below owns the valid flag
            if (out_valid_reg && m_tready && (state_reg != ST_EMIT))
                out_valid_reg <= 1'b0;

            unique case (state_reg)
                ST_IDLE:
                begin
                    if (in_accept)
                    begin
                        sum_reg   <= sum_next;
                        count_reg <= count_next;
                        ign_reg   <= in_ign;
                        if (mode_reg == ivd_pkg::MODE_ON)
                            run_time_reg <= run_time_reg + RW'(1);
                        pend_started_reg <= 1'b0;
                        pend_stopped_reg <= 1'b0;
                        pend_stop_reg    <= 1'b0;
                        if (window_close)
                        begin
                            pend_done_reg <= 1'b1;
                            quo_reg       <= sum_next;
                            rem_reg       <= '0;
                            bit_cnt_reg   <= BW'(UW);
                            state_reg     <= ST_DIV;
                        end
                        else
                        begin
                            pend_done_reg <= 1'b0;
                            state_reg     <= ST_EMIT;
                        end
                    end
                end

                ST_DIV:
                begin
                    quo_reg     <= {quo_reg[UW-2:0], rem_ge};
                    rem_reg     <= rem_ge ? rem_diff[CW-1:0] : rem_shift[CW-1:0];
                    bit_cnt_reg <= bit_cnt_reg - BW'(1);
                    if (bit_cnt_reg == BW'(1))
                        state_reg <= ST_DECIDE;
                end

                ST_DECIDE:
                begin
                    last_avg_reg <= avg_sat;
                    // on wins when both thresholds are met
                    if (ign_reg && (avg_sat >= on_thr_reg))
                    begin
                        mode_reg         <= ivd_pkg::MODE_ON;
                        pend_started_reg <= 1'b1;
                    end
                    else if (ign_reg && (avg_sat <= off_thr_reg))
                    begin
                        if (mode_reg == ivd_pkg::MODE_ON)
                        begin
                            pend_stopped_reg <= 1'b1;
                            pend_stop_reg    <= 1'b1;
                            run_time_reg     <= '0;
                        end
                        mode_reg <= ivd_pkg::MODE_OFF;
                    end
                    if (!ign_reg)
                        pend_stop_reg <= 1'b1;
                    sum_reg   <= '0;
                    count_reg <= '0;
                    state_reg <= ST_EMIT;
                end

                ST_EMIT:
                begin
                    if (out_free)
                    begin
                        out_valid_reg   <= 1'b1;
                        out_done_reg    <= pend_done_reg;
                        out_avg_reg     <= last_avg_reg;
                        out_mode_reg    <= mode_reg;
                        out_started_reg <= pend_started_reg;
                        out_stopped_reg <= pend_stopped_reg;
                        out_run_reg     <= run_time_reg;
                        out_stop_reg    <= pend_stop_reg;
                        state_reg       <= ST_IDLE;
                    end
                end

                default:
                    state_reg <= ST_IDLE;
            endcase
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {{PAD_WIDTH{1'b0}}, out_stop_reg, out_run_reg, out_stopped_reg,
                       out_started_reg, out_mode_reg, out_avg_reg, out_done_reg};

    `IVD_ASSERT(a_div_count_live, (state_reg == ST_DIV) |-> (bit_cnt_reg != '0),
        "divider running with no bits left")
    `IVD_ASSERT(a_rem_below_divisor, (state_reg == ST_DIV) |-> (rem_reg < count_reg),
        "partial remainder not below divisor")
    `IVD_ASSERT(a_busy_after_accept, in_accept |=> !s_tready,
        "sample taken while previous one still in work")
    `IVD_ASSERT(a_flags_need_window, (out_valid_reg && !out_done_reg) |->
        (!out_started_reg && !out_stopped_reg && !out_stop_reg),
        "event flags raised without a closed window")
    `IVD_ASSERT_ALWAYS(a_start_stop_exclusive, !(out_started_reg && out_stopped_reg),
        "start and stop flagged in one result")

endmodule
